>>> sv/psg_pkg.sv
// Package for the plan step guard: widths, codes, payload structs and states.
`timescale 1ns / 1ps
package psg_pkg;
  localparam int MaxSteps = 32;
  localparam int MaxRun = 8;
  localparam int TokenBits = 16;
  localparam int IdxW = $clog2(MaxSteps);
  localparam int CntW = 6;
  localparam int SumW = 22;
  localparam int DivW = 16;

  typedef enum logic [2:0] {
    STOP_END = 3'd0, STOP_SCORE = 3'd1, STOP_SUPPORT = 3'd2,
    STOP_DROP = 3'd3, STOP_REPEAT = 3'd4, STOP_CYCLE = 3'd5
  } stop_e;

  typedef enum logic [1:0] {
    CFG_MIN_SCORE = 2'd0, CFG_MIN_SUPPORT = 2'd1, CFG_MAX_DROP = 2'd2,
    CFG_MAX_REPEAT = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] step_score;
    logic [15:0] step_support;
    logic [15:0] token_id;
    logic        step_present;
    logic        plan_last;
    logic [3:0]  plan_end_reason;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  stop_code;
    logic [3:0]  echo_end_reason;
    logic [5:0]  stop_step;
    logic [5:0]  accepted_count;
    logic [15:0] evidence_score;
    logic [15:0] evidence_support;
    logic [15:0] prior_score;
    logic [15:0] evidence_token;
    logic [5:0]  repeat_count;
    logic [5:0]  cycle_start;
    logic [15:0] mean_score;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_sts_t;
endpackage

>>> sv/psg_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module psg_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write and read one entry per cycle; a read during a write returns the old entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> sv/psg_div.sv
// Restoring divider: one quotient bit per cycle for the mean score.
`timescale 1ns / 1ps
module psg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psg_pkg::div_ctl_t   ctl_i,
  output psg_pkg::div_sts_t   sts_o
);
  import psg_pkg::*;

  logic [SumW-1:0] rem_q, rem_d;
  logic [SumW-1:0] num_q, num_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [SumW-1:0] trial;

  // shift in one dividend bit and try a subtract
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[SumW-2:0], num_q[SumW-1]};
    if (ctl_i.start) begin
      rem_d  = '0;
      num_d  = ctl_i.dividend;
      quo_d  = '0;
      cnt_d  = 5'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[SumW-2:0], 1'b0};
      if (trial >= SumW'(ctl_i.divisor)) begin
        rem_d = trial - SumW'(ctl_i.divisor);
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign sts_o.done     = busy_q && (cnt_q == 5'd1);
  assign sts_o.quotient = quo_d;

`ifndef SYNTHESIS
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 5'd0) else $error("divider busy with zero count");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done && !ctl_i.start |=> !busy_q) else $error("divider kept running");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q) else $error("divider did not start");
`endif
endmodule

>>> sv/plan_step_guard.sv
// Top level of the plan step guard.
`timescale 1ns / 1ps
// Plan step guard. Each input word is one plan step; a word with plan_last
// gives one result word. A step scans the tokens already accepted in the
// plan: the token store is a single-port RAM scanned one entry a cycle from
// the newest backward (run count and cycle search share that pass). A step
// stopped by the score, support or drop guard, or a word with no step, skips
// the scan. A plan_last word then runs the serial mean divider (skipped when
// no step was accepted) and holds the result word while the receiver stalls.
// The block takes no word while a step is in work or a result waits.
module plan_step_guard (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  psg_pkg::in_word_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output psg_pkg::out_word_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import psg_pkg::*;

  state_e state_q, state_d;
  in_word_t in_q;
  out_word_t res_q, res_d;
  logic [15:0] min_score_q, min_sup_q, max_drop_q;
  logic [3:0]  max_rep_q;
  logic [CntW-1:0] acc_q, acc_d, seen_q, seen_d, ptr_q, ptr_d;
  logic [CntW-1:0] run_q, run_d, cyc_q, cyc_d;
  logic        in_run_q, in_run_d, stop_q, stop_d, rd_q, rd_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [15:0] last_q, last_d, second_q, second_d, lsup_q, lsup_d;
  logic [15:0] ltok_q, ltok_d;
  logic        ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [15:0] ram_rd;
  div_ctl_t    div_ctl;
  div_sts_t    div_sts;
  logic        accept, is_step;
  logic [CntW-1:0] lim;
  logic [15:0] tok;
  logic [2:0]  code;

  assign accept = in_valid_i && !in_stall_o;
  assign tok = in_q.token_id[TokenBits-1:0];
  assign is_step = in_q.step_present && !stop_q && (seen_q < CntW'(MaxSteps));

  // clamp the run limit
  always_comb begin
    if (max_rep_q == 4'd0) lim = CntW'(1);
    else if (32'(max_rep_q) > MaxRun) lim = CntW'(MaxRun);
    else lim = CntW'(max_rep_q);
  end

  // write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q <= 16'd9830;
      min_sup_q   <= 16'd16384;
      max_drop_q  <= 16'd26214;
      max_rep_q   <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_MIN_SCORE:   min_score_q <= cfg_data_i;
        CFG_MIN_SUPPORT: min_sup_q   <= cfg_data_i;
        CFG_MAX_DROP:    max_drop_q  <= cfg_data_i;
        CFG_MAX_REPEAT:  max_rep_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  psg_ram #(.Width(16), .Depth(MaxSteps)) u_tokens (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(tok), .rdata_o(ram_rd)
  );

  psg_div u_div (.clk_i, .rst_ni, .ctl_i(div_ctl), .sts_o(div_sts));

  // next state: the scan ends once entry zero has been checked, or at once on a guard stop or a word with no step
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: begin
        if (!is_step || ptr_q == '0 || code != STOP_END)
          state_d = in_q.plan_last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: if (div_sts.done || acc_q == '0) state_d = ST_OUT;
      ST_OUT: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // early guards on score, support and drop
  always_comb begin
    code = STOP_END;
    if (is_step) begin
      if (in_q.step_score < min_score_q) code = STOP_SCORE;
      else if (in_q.step_support < min_sup_q) code = STOP_SUPPORT;
      else if (acc_q != '0 && last_q > in_q.step_score &&
               (last_q - in_q.step_score) > max_drop_q) code = STOP_DROP;
    end
  end

  // scan the token store and update plan state
  always_comb begin
    acc_d = acc_q; seen_d = seen_q; ptr_d = ptr_q; run_d = run_q;
    cyc_d = cyc_q; in_run_d = in_run_q; stop_d = stop_q; rd_d = rd_q;
    sum_d = sum_q; last_d = last_q; second_d = second_q; lsup_d = lsup_q;
    ltok_d = ltok_q; res_d = res_q;
    ram_we = 1'b0;
    ram_addr = ptr_q[IdxW-1:0];
    div_ctl.start = 1'b0;
    div_ctl.dividend = sum_q;
    div_ctl.divisor = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        ptr_d = acc_q;
        run_d = CntW'(1);
        in_run_d = 1'b1;
        cyc_d = CntW'(MaxSteps);
        rd_d = 1'b0;
      end
      ST_SCAN: begin
        if (is_step && code != STOP_END) begin
          stop_d = 1'b1;
        end else if (is_step) begin
          // issue reads from newest entry down, check the previous read;
          // the lowest matching index wins the cycle search
          if (rd_q) begin
            if (in_run_q && ram_rd == tok) begin
              run_d = run_q + CntW'(1);
            end else begin
              in_run_d = 1'b0;
            end
            if (ram_rd == tok) cyc_d = ptr_q;
          end
          if (ptr_q != '0) begin
            ptr_d = ptr_q - CntW'(1);
            ram_addr = ptr_d[IdxW-1:0];
            rd_d = 1'b1;
          end else begin
            ram_addr = acc_q[IdxW-1:0];
          end
        end
        if (state_d != ST_SCAN) begin
          if (is_step) begin
            seen_d = seen_q + CntW'(1);
            if (code != STOP_END) begin
              res_d = '0;
              res_d.stop_code = code;
              res_d.stop_step = seen_q;
              res_d.evidence_score = in_q.step_score;
              res_d.evidence_support = in_q.step_support;
              res_d.prior_score = (acc_q != '0) ? last_q : 16'd0;
              res_d.evidence_token = tok;
              res_d.cycle_start = CntW'(MaxSteps);
              res_d.accepted_count = acc_q;
            end else if (acc_q != '0 && ltok_q == tok && run_d > lim) begin
              stop_d = 1'b1;
              res_d = '0;
              res_d.stop_code = STOP_REPEAT;
              res_d.stop_step = seen_q;
              res_d.evidence_score = in_q.step_score;
              res_d.evidence_support = in_q.step_support;
              res_d.prior_score = last_q;
              res_d.evidence_token = tok;
              res_d.repeat_count = run_d;
              res_d.cycle_start = CntW'(MaxSteps);
              res_d.accepted_count = acc_q;
            end else if (acc_q != '0 && ltok_q != tok && cyc_d != CntW'(MaxSteps)) begin
              stop_d = 1'b1;
              res_d = '0;
              res_d.stop_code = STOP_CYCLE;
              res_d.stop_step = seen_q;
              res_d.evidence_score = in_q.step_score;
              res_d.evidence_support = in_q.step_support;
              res_d.prior_score = last_q;
              res_d.evidence_token = tok;
              res_d.cycle_start = cyc_d;
              res_d.accepted_count = acc_q;
            end else begin
              ram_we = 1'b1;
              ram_addr = acc_q[IdxW-1:0];
              second_d = last_q;
              last_d = in_q.step_score;
              lsup_d = in_q.step_support;
              ltok_d = tok;
              sum_d = sum_q + SumW'(in_q.step_score);
              acc_d = acc_q + CntW'(1);
            end
          end
          if (in_q.plan_last) begin
            div_ctl.start = 1'b1;
            div_ctl.dividend = sum_d;
            if (!stop_d) begin
              res_d = '0;
              res_d.echo_end_reason = in_q.plan_end_reason;
              res_d.stop_step = acc_d;
              res_d.accepted_count = acc_d;
              res_d.cycle_start = CntW'(MaxSteps);
              if (acc_d != '0) begin
                res_d.evidence_score = last_d;
                res_d.evidence_support = lsup_d;
                res_d.evidence_token = ltok_d;
                res_d.prior_score = (acc_d > CntW'(1)) ? second_d : 16'd0;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) res_d.mean_score = div_sts.quotient;
        else if (acc_q == '0) res_d.mean_score = '0;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          acc_d = '0; seen_d = '0; stop_d = 1'b0; sum_d = '0;
          last_d = '0; second_d = '0; lsup_d = '0; ltok_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q <= '0; seen_q <= '0; stop_q <= 1'b0; sum_q <= '0;
      last_q <= '0; second_q <= '0; lsup_q <= '0; ltok_q <= '0;
      ptr_q <= '0; run_q <= '0; cyc_q <= '0; in_run_q <= 1'b0; rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d; seen_q <= seen_d; stop_q <= stop_d; sum_q <= sum_d;
      last_q <= last_d; second_q <= second_d; lsup_q <= lsup_d; ltok_q <= ltok_d;
      ptr_q <= ptr_d; run_q <= run_d; cyc_q <= cyc_d; in_run_q <= in_run_d;
      rd_q <= rd_d;
    end
  end

  // hold the input word and the result
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_acc_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= seen_q) else $error("accepted count above steps seen");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> acc_q == '0 && !stop_q)
    else $error("plan state not cleared");
  a_seen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CntW'(MaxSteps)) else $error("step count overflow");
`endif
endmodule
